// ----- hw/rtl/rgb_to_ycbcr420_converter_core_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef RGB_TO_YCBCR420_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_YCBCR420_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define R2Y_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r2y assertion failed");

// Next-cycle implication, disabled during reset.
`define R2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2y assertion failed");

`endif

// ----- hw/rtl/r2y_pkg.sv -----
`timescale 1ns / 1ps

package r2y_pkg;

    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 12;
    localparam int PAIR_W  = 13;   // clamped pair count, up to 4095
    localparam int LAST_W  = 14;   // last row or column index
    localparam int PROD_W  = 16;
    localparam int SUM_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] HALF_WIDTH_RST  = 12'd960;
    localparam logic [SIZE_W-1:0] HALF_HEIGHT_RST = 12'd540;

    // BT.601 coefficients, 8 fraction bits
    localparam logic [PIX_W-1:0] Y_R  = 8'd66;
    localparam logic [PIX_W-1:0] Y_G  = 8'd129;
    localparam logic [PIX_W-1:0] Y_B  = 8'd25;
    localparam logic [PIX_W-1:0] CB_R = 8'd38;   // subtracted
    localparam logic [PIX_W-1:0] CB_G = 8'd74;   // subtracted
    localparam logic [PIX_W-1:0] CB_B = 8'd112;
    localparam logic [PIX_W-1:0] CR_R = 8'd112;
    localparam logic [PIX_W-1:0] CR_G = 8'd94;   // subtracted
    localparam logic [PIX_W-1:0] CR_B = 8'd18;   // subtracted

    localparam logic [SUM_W-1:0] ROUND_HALF  = 17'd128;
    localparam logic [SUM_W-1:0] CHROMA_BIAS = 17'd32896;  // 128 << 8 plus rounding
    localparam logic [PIX_W-1:0] LUMA_OFFSET = 8'd16;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        pix_t pix;
        logic chroma_valid;
        logic row_end;
        logic frame_end;
    } q_entry_t;

    typedef struct packed {
        logic              we;
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- hw/rtl/r2y_stream_if.sv -----
`timescale 1ns / 1ps

interface r2y_rgb_if;
    logic                     valid;
    logic                     ready;
    logic [r2y_pkg::PIX_W-1:0] red;
    logic [r2y_pkg::PIX_W-1:0] green;
    logic [r2y_pkg::PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface r2y_ycc_if;
    logic                     valid;
    logic                     ready;
    logic [r2y_pkg::PIX_W-1:0] luma;
    logic                     chroma_valid;
    logic [r2y_pkg::PIX_W-1:0] chroma_blue;
    logic [r2y_pkg::PIX_W-1:0] chroma_red;
    logic                     row_end;
    logic                     frame_end;

    modport source (output valid, output luma, output chroma_valid, output chroma_blue,
                    output chroma_red, output row_end, output frame_end, input ready);
    modport sink   (input valid, input luma, input chroma_valid, input chroma_blue,
                    input chroma_red, input row_end, input frame_end, output ready);
endinterface

// ----- hw/rtl/r2y_front.sv -----
`timescale 1ns / 1ps

module r2y_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  r2y_pkg::cfg_wr_t    cfg,
    r2y_rgb_if.sink             pixels,
    input  logic                q_full,
    output logic                q_push,
    output r2y_pkg::q_entry_t   q_data
);

    localparam int HW_LIM = (MAX_WIDTH / 2 < 1) ? 1 : MAX_WIDTH / 2;
    localparam int HH_LIM = (MAX_HEIGHT / 2 < 1) ? 1 : MAX_HEIGHT / 2;
    localparam logic [r2y_pkg::PAIR_W-1:0] W_LIMIT = r2y_pkg::PAIR_W'(HW_LIM);
    localparam logic [r2y_pkg::PAIR_W-1:0] H_LIMIT = r2y_pkg::PAIR_W'(HH_LIM);

    logic [r2y_pkg::SIZE_W-1:0] half_width_reg, half_height_reg;
    logic [r2y_pkg::SIZE_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [r2y_pkg::PAIR_W-1:0] w_pairs, h_pairs;
    logic [r2y_pkg::LAST_W-1:0] last_col, last_row;
    logic                       at_row_end, at_last_row, accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= r2y_pkg::HALF_WIDTH_RST;
            half_height_reg <= r2y_pkg::HALF_HEIGHT_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                r2y_pkg::CFG_HALF_WIDTH:  half_width_reg  <= cfg.data;
                r2y_pkg::CFG_HALF_HEIGHT: half_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // zero acts as one pair, oversize clamps to the frame limit
    always_comb
    begin
        w_pairs = {1'b0, half_width_reg};
        if (w_pairs == '0)
            w_pairs = r2y_pkg::PAIR_W'(1);
        if (w_pairs > W_LIMIT)
            w_pairs = W_LIMIT;
        h_pairs = {1'b0, half_height_reg};
        if (h_pairs == '0)
            h_pairs = r2y_pkg::PAIR_W'(1);
        if (h_pairs > H_LIMIT)
            h_pairs = H_LIMIT;
    end

    assign last_col    = {w_pairs, 1'b0} - r2y_pkg::LAST_W'(1);
    assign last_row    = {h_pairs, 1'b0} - r2y_pkg::LAST_W'(1);
    assign at_row_end  = {2'b00, col_reg} >= last_col;
    assign at_last_row = {2'b00, row_reg} >= last_row;

    assign pixels.ready = !q_full;
    assign accept       = pixels.valid && !q_full;
    assign q_push       = accept;

    always_comb
    begin
        q_data.pix.red     = pixels.red;
        q_data.pix.green   = pixels.green;
        q_data.pix.blue    = pixels.blue;
        q_data.chroma_valid = !col_reg[0] && !row_reg[0];
        q_data.row_end     = at_row_end;
        q_data.frame_end   = at_row_end && at_last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (at_row_end)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- hw/rtl/r2y_queue.sv -----
`timescale 1ns / 1ps

module r2y_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  r2y_pkg::q_entry_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output r2y_pkg::q_entry_t head_data
);

    localparam int AW = (r2y_pkg::QUEUE_DEPTH > 1) ? $clog2(r2y_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(r2y_pkg::QUEUE_DEPTH + 1);

    r2y_pkg::q_entry_t   mem_reg [r2y_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = count_reg == CW'(r2y_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(r2y_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(r2y_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/r2y_back.sv -----
`timescale 1ns / 1ps

module r2y_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  r2y_pkg::q_entry_t head_data,
    output logic              pop,
    r2y_ycc_if.source         samples
);

    typedef logic [r2y_pkg::PROD_W-1:0] prod_t;

    // stage 1: constant products
    logic  s1_valid_reg;
    prod_t y_r_reg, y_g_reg, y_b_reg;
    prod_t cb_r_reg, cb_g_reg, cb_b_reg;
    prod_t cr_r_reg, cr_g_reg, cr_b_reg;
    logic  s1_cv_reg, s1_re_reg, s1_fe_reg;

    // stage 2: output word
    logic                      s2_valid_reg;
    logic [r2y_pkg::PIX_W-1:0] luma_reg, cb_reg, cr_reg;
    logic                      cv_reg, re_reg, fe_reg;

    logic                      s1_ready, s2_ready;
    logic [r2y_pkg::SUM_W-1:0] y_sum, cb_sum, cr_sum;
    r2y_pkg::pix_t             p;

    assign s2_ready = !s2_valid_reg || samples.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = head_valid && s1_ready;
    assign p        = head_data.pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= head_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            y_r_reg   <= prod_t'(p.red)   * prod_t'(r2y_pkg::Y_R);
            y_g_reg   <= prod_t'(p.green) * prod_t'(r2y_pkg::Y_G);
            y_b_reg   <= prod_t'(p.blue)  * prod_t'(r2y_pkg::Y_B);
            cb_r_reg  <= prod_t'(p.red)   * prod_t'(r2y_pkg::CB_R);
            cb_g_reg  <= prod_t'(p.green) * prod_t'(r2y_pkg::CB_G);
            cb_b_reg  <= prod_t'(p.blue)  * prod_t'(r2y_pkg::CB_B);
            cr_r_reg  <= prod_t'(p.red)   * prod_t'(r2y_pkg::CR_R);
            cr_g_reg  <= prod_t'(p.green) * prod_t'(r2y_pkg::CR_G);
            cr_b_reg  <= prod_t'(p.blue)  * prod_t'(r2y_pkg::CR_B);
            s1_cv_reg <= head_data.chroma_valid;
            s1_re_reg <= head_data.row_end;
            s1_fe_reg <= head_data.frame_end;
        end
    end

    // chroma sums stay in 0..65535 thanks to the bias, so bits 15:8 are exact
    assign y_sum  = r2y_pkg::SUM_W'(y_r_reg) + r2y_pkg::SUM_W'(y_g_reg)
                  + r2y_pkg::SUM_W'(y_b_reg) + r2y_pkg::ROUND_HALF;
    assign cb_sum = r2y_pkg::SUM_W'(cb_b_reg) + r2y_pkg::CHROMA_BIAS
                  - r2y_pkg::SUM_W'(cb_r_reg) - r2y_pkg::SUM_W'(cb_g_reg);
    assign cr_sum = r2y_pkg::SUM_W'(cr_r_reg) + r2y_pkg::CHROMA_BIAS
                  - r2y_pkg::SUM_W'(cr_g_reg) - r2y_pkg::SUM_W'(cr_b_reg);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            luma_reg <= y_sum[15:8] + r2y_pkg::LUMA_OFFSET;
            cb_reg   <= s1_cv_reg ? cb_sum[15:8] : '0;
            cr_reg   <= s1_cv_reg ? cr_sum[15:8] : '0;
            cv_reg   <= s1_cv_reg;
            re_reg   <= s1_re_reg;
            fe_reg   <= s1_fe_reg;
        end
    end

    assign samples.valid        = s2_valid_reg;
    assign samples.luma         = luma_reg;
    assign samples.chroma_valid = cv_reg;
    assign samples.chroma_blue  = cb_reg;
    assign samples.chroma_red   = cr_reg;
    assign samples.row_end      = re_reg;
    assign samples.frame_end    = fe_reg;

endmodule

// ----- hw/rtl/rgb_to_ycbcr420_converter_core.sv -----
`timescale 1ns / 1ps
// An accepted pixel word passes through the queue, the products and the sums registers to
// its result word. Throughput: one pixel per cycle while the output is not stalled; the
// two-entry queue and the output register let input and output stall independently.
// Reset (rst_n low, async): counters to row 0 column 0, queue and pipeline emptied,
// half_width 960 and half_height 540.
module rgb_to_ycbcr420_converter_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [r2y_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [r2y_pkg::SIZE_W-1:0]          cfg_data,
    r2y_rgb_if.sink                             pixels,
    r2y_ycc_if.source                           samples
);

    r2y_pkg::cfg_wr_t  cfg;
    r2y_pkg::q_entry_t push_data, head_data;
    logic              push, full, pop, head_valid;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    r2y_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pixels (pixels),
        .q_full (full),
        .q_push (push),
        .q_data (push_data)
    );

    r2y_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    r2y_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .samples    (samples)
    );

endmodule

// ----- hw/rtl/r2y_checker.sv -----
`timescale 1ns / 1ps
`include "rgb_to_ycbcr420_converter_core_macros.svh"

module r2y_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      word_valid,
    input logic                      word_ready,
    input logic [r2y_pkg::PIX_W-1:0] luma,
    input logic                      chroma_valid,
    input logic [r2y_pkg::PIX_W-1:0] chroma_blue,
    input logic [r2y_pkg::PIX_W-1:0] chroma_red,
    input logic                      row_end,
    input logic                      frame_end
);

    `R2Y_ASSERT_NOW(a_frame_end_on_row_end, clk, rst_n, word_valid && frame_end, row_end)

    `R2Y_ASSERT_NOW(a_luma_range, clk, rst_n, word_valid, luma >= 8'd16 && luma <= 8'd235)

    // no chroma on words off the 2x2 grid
    `R2Y_ASSERT_NOW(a_chroma_zero, clk, rst_n, word_valid && !chroma_valid,
                    chroma_blue == '0 && chroma_red == '0)

    `R2Y_ASSERT_NEXT(a_stall_hold, clk, rst_n, word_valid && !word_ready,
                     word_valid && $stable(luma) && $stable(chroma_blue) && $stable(frame_end))

endmodule

bind rgb_to_ycbcr420_converter_core r2y_checker u_r2y_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (samples.valid),
    .word_ready   (samples.ready),
    .luma         (samples.luma),
    .chroma_valid (samples.chroma_valid),
    .chroma_blue  (samples.chroma_blue),
    .chroma_red   (samples.chroma_red),
    .row_end      (samples.row_end),
    .frame_end    (samples.frame_end)
);

// ----- bench/rgb_to_ycbcr420_converter_core_tb.sv -----
`timescale 1ns / 1ps

module rgb_to_ycbcr420_converter_core_tb;

    localparam int PIX_W     = r2y_pkg::PIX_W;
    localparam int SIZE_W    = r2y_pkg::SIZE_W;
    localparam int CFG_IDX_W = r2y_pkg::CFG_IDX_W;

    localparam int FRAME_MAX_W   = 4096;
    localparam int FRAME_MAX_H   = 4096;
    localparam int PIPE_LATENCY  = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 500;
    localparam int TAIL_PIXELS   = 100;   // final stretch runs with no idling
    localparam int MAX_REPORTS   = 40;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // BT.601 studio range, 8 fraction bits
    localparam int Y_KR  = 66;
    localparam int Y_KG  = 129;
    localparam int Y_KB  = 25;
    localparam int CB_KR = -38;
    localparam int CB_KG = -74;
    localparam int CB_KB = 112;
    localparam int CR_KR = 112;
    localparam int CR_KG = -94;
    localparam int CR_KB = -18;
    localparam int ROUNDING    = 128;
    localparam int CHROMA_BIAS = 128 << 8;
    localparam int LUMA_BASE   = 16;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             row_end;
        logic             frame_end;
    } ycc_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    r2y_rgb_if pixel_bus ();
    r2y_ycc_if sample_bus ();

    rgb_to_ycbcr420_converter_core #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixel_bus),
        .samples   (sample_bus)
    );

    always #2 clk = ~clk;

    // converter state as the testbench sees it
    logic [SIZE_W-1:0] half_width_cfg  = r2y_pkg::HALF_WIDTH_RST;
    logic [SIZE_W-1:0] half_height_cfg = r2y_pkg::HALF_HEIGHT_RST;
    logic [SIZE_W-1:0] col_pos = '0;
    logic [SIZE_W-1:0] row_pos = '0;

    r2y_pkg::pix_t pixel_backlog[$];
    ycc_word_t     ycc_expected[$];

    int  pixels_queued   = 0;
    int  pixels_accepted = 0;
    int  words_checked   = 0;
    int  mismatch_count  = 0;
    int  chroma_count    = 0;
    int  row_end_count   = 0;
    int  frame_end_count = 0;
    int  reg_writes      = 0;
    int  random_pixels   = 0;
    int  cycle_count     = 0;
    int  send_gap        = 0;
    int  hold_left       = 0;
    bit  idle_enabled    = 1'b0;
    r2y_pkg::pix_t next_pix;

    function automatic int clamp_pairs(input int pairs, input int max_full);
        int limit;
        limit = max_full / 2;
        if (limit == 0)
            limit = 1;
        if (pairs == 0)
            pairs = 1;
        if (pairs > limit)
            pairs = limit;
        return pairs;
    endfunction

    // converts one pixel and steps the raster position
    function automatic ycc_word_t convert_pixel(input r2y_pkg::pix_t p);
        ycc_word_t w;
        int rv, gv, bv;
        int last_col, last_row, y_sum, cb_sum, cr_sum;
        bit chroma_site;
        rv = p.red;
        gv = p.green;
        bv = p.blue;
        last_col = 2 * clamp_pairs(half_width_cfg, FRAME_MAX_W) - 1;
        last_row = 2 * clamp_pairs(half_height_cfg, FRAME_MAX_H) - 1;
        chroma_site = !col_pos[0] && !row_pos[0];

        y_sum  = Y_KR * rv + Y_KG * gv + Y_KB * bv + ROUNDING;
        cb_sum = CB_KR * rv + CB_KG * gv + CB_KB * bv + ROUNDING + CHROMA_BIAS;
        cr_sum = CR_KR * rv + CR_KG * gv + CR_KB * bv + ROUNDING + CHROMA_BIAS;

        w.luma         = PIX_W'((y_sum >>> 8) + LUMA_BASE);
        w.chroma_valid = chroma_site;
        w.chroma_blue  = chroma_site ? PIX_W'(cb_sum >>> 8) : '0;
        w.chroma_red   = chroma_site ? PIX_W'(cr_sum >>> 8) : '0;
        // a shrunk size leaves counters past the end: they end the row there
        w.row_end      = (col_pos >= last_col);
        w.frame_end    = w.row_end && (row_pos >= last_row);

        if (w.row_end)
        begin
            col_pos = '0;
            if (row_pos >= last_row)
                row_pos = '0;
            else
                row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end

        chroma_count    += chroma_site;
        row_end_count   += w.row_end;
        frame_end_count += w.frame_end;
        return w;
    endfunction

    function automatic logic [PIX_W-1:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_pairs();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SIZE_W'(2048);
            2:       return '1;
            3:       return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] word %0d: %s", $realtime, words_checked, msg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        if (idx == r2y_pkg::CFG_HALF_WIDTH)
            half_width_cfg = data;
        else if (idx == r2y_pkg::CFG_HALF_HEIGHT)
            half_height_cfg = data;
        reg_writes++;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] r, g, b);
        r2y_pkg::pix_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        pixel_backlog.push_back(p);
        pixels_queued++;
    endtask

    task automatic queue_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
            else
                queue_pixel(random_channel(), random_channel(), random_channel());
            random_pixels++;
        end
    endtask

    task automatic wait_drained();
        while (pixels_accepted != pixels_queued || ycc_expected.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // pixel driver; the expectation is formed when a word is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bus.valid <= 1'b0;
            pixel_bus.red   <= '0;
            pixel_bus.green <= '0;
            pixel_bus.blue  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                next_pix.red   = pixel_bus.red;
                next_pix.green = pixel_bus.green;
                next_pix.blue  = pixel_bus.blue;
                ycc_expected.push_back(convert_pixel(next_pix));
                pixels_accepted++;
            end
            if (!pixel_bus.valid || pixel_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pixel_bus.valid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    next_pix = pixel_backlog.pop_front();
                    pixel_bus.valid <= 1'b1;
                    pixel_bus.red   <= next_pix.red;
                    pixel_bus.green <= next_pix.green;
                    pixel_bus.blue  <= next_pix.blue;
                    if (idle_enabled && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 12);
                end
                else
                begin
                    pixel_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            sample_bus.ready <= 1'b0;
        end
        else
        begin
            sample_bus.ready <= 1'b1;
            if (idle_enabled && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 12);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        ycc_word_t exp_w;
        if (rst_n && sample_bus.valid && sample_bus.ready)
        begin
            words_checked++;
            if (ycc_expected.size() == 0)
            begin
                report_mismatch($sformatf("result word with no pixel pending (luma %0d)",
                                          sample_bus.luma));
            end
            else
            begin
                exp_w = ycc_expected.pop_front();
                if (sample_bus.luma !== exp_w.luma)
                    report_mismatch($sformatf("luma %0d, expected %0d",
                                              sample_bus.luma, exp_w.luma));
                if (sample_bus.chroma_valid !== exp_w.chroma_valid)
                    report_mismatch($sformatf("chroma_valid %b, expected %b",
                                              sample_bus.chroma_valid, exp_w.chroma_valid));
                if (sample_bus.chroma_blue !== exp_w.chroma_blue)
                    report_mismatch($sformatf("chroma_blue %0d, expected %0d",
                                              sample_bus.chroma_blue, exp_w.chroma_blue));
                if (sample_bus.chroma_red !== exp_w.chroma_red)
                    report_mismatch($sformatf("chroma_red %0d, expected %0d",
                                              sample_bus.chroma_red, exp_w.chroma_red));
                if (sample_bus.row_end !== exp_w.row_end)
                    report_mismatch($sformatf("row_end %b, expected %b",
                                              sample_bus.row_end, exp_w.row_end));
                if (sample_bus.frame_end !== exp_w.frame_end)
                    report_mismatch($sformatf("frame_end %b, expected %b",
                                              sample_bus.frame_end, exp_w.frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d pixels taken, %0d words pending",
                     cycle_count, pixels_accepted, pixels_queued, ycc_expected.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int choice;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = r2y_pkg::CFG_HALF_WIDTH;
        cfg_data         = '0;
        pixel_bus.valid  = 1'b0;
        pixel_bus.red    = '0;
        pixel_bus.green  = '0;
        pixel_bus.blue   = '0;
        sample_bus.ready = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes: corners of the color cube along the top row
        queue_pixel(8'd0,   8'd0,   8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0,   8'd0);
        queue_pixel(8'd0,   8'd255, 8'd0);
        queue_pixel(8'd0,   8'd0,   8'd255);
        queue_pixel(8'd0,   8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0,   8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        wait_drained();

        // shrink mid-row: column 8 is already past the end of a 2-wide row
        write_reg(r2y_pkg::CFG_HALF_WIDTH, 12'd1);
        write_reg(r2y_pkg::CFG_HALF_HEIGHT, 12'd0);
        queue_pixel(8'd255, 8'd0,   8'd0);
        queue_pixel(8'd0,   8'd255, 8'd255);
        queue_pixel(8'd16,  8'd128, 8'd240);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0,   8'd0,   8'd0);
        queue_pixel(8'd128, 8'd128, 8'd128);
        wait_drained();

        write_reg(r2y_pkg::CFG_HALF_WIDTH, 12'd0);
        write_reg(r2y_pkg::CFG_HALF_HEIGHT, 12'd1);
        queue_pixel(8'd0,   8'd0,   8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0,   8'd255, 8'd0);
        queue_pixel(8'd255, 8'd0,   8'd255);
        wait_drained();

        write_reg(CFG_SPARE_LO, 12'hFFF);
        write_reg(CFG_SPARE_HI, 12'h000);
        queue_pixel(8'd1,   8'd2,   8'd4);
        queue_pixel(8'd254, 8'd253, 8'd251);
        queue_pixel(8'd170, 8'd85,  8'd170);
        queue_pixel(8'd85,  8'd170, 8'd85);
        wait_drained();

        // largest sizes, then shrink the row and the frame under the counters
        idle_enabled = 1'b1;
        write_reg(r2y_pkg::CFG_HALF_WIDTH, 12'hFFF);
        write_reg(r2y_pkg::CFG_HALF_HEIGHT, 12'd2048);
        queue_random(30);
        wait_drained();
        write_reg(r2y_pkg::CFG_HALF_WIDTH, 12'd2);
        queue_random(14);
        wait_drained();
        write_reg(r2y_pkg::CFG_HALF_HEIGHT, 12'd1);
        queue_random(14);
        wait_drained();

        while (random_pixels < RANDOM_PIXELS)
        begin
            idle_enabled = (random_pixels < RANDOM_PIXELS - TAIL_PIXELS) &&
                           ($urandom_range(0, 3) != 0);
            choice = $urandom_range(0, 9);
            if (choice < 6)
            begin
                write_reg(r2y_pkg::CFG_HALF_WIDTH, SIZE_W'($urandom_range(1, 4)));
                write_reg(r2y_pkg::CFG_HALF_HEIGHT, SIZE_W'($urandom_range(1, 3)));
            end
            else if (choice == 6)
                write_reg(r2y_pkg::CFG_HALF_WIDTH, random_pairs());
            else if (choice == 7)
                write_reg(r2y_pkg::CFG_HALF_HEIGHT, random_pairs());
            else if (choice == 8)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          SIZE_W'($urandom));
            queue_random($urandom_range(16, 48));
            wait_drained();
        end

        if (ycc_expected.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", ycc_expected.size()));

        $display("checked %0d words from %0d pixels: %0d chroma samples,",
                 words_checked, pixels_accepted, chroma_count);
        $display("%0d row ends, %0d frame ends, %0d register writes incl. zero, clamped",
                 row_end_count, frame_end_count, reg_writes);
        $display("and ignored-index cases; %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
